// ===== src/pwds_pkg.sv =====
// Shared types, codes and widths for the periodic window deadline scheduler.
package pwds_pkg;

  // Event kinds carried on in_tuser
  localparam logic [2:0] KIND_TICK    = 3'd0;
  localparam logic [2:0] KIND_START   = 3'd1;
  localparam logic [2:0] KIND_END     = 3'd2;
  localparam logic [2:0] KIND_PAUSE   = 3'd3;
  localparam logic [2:0] KIND_RESUME  = 3'd4;
  localparam logic [2:0] KIND_RESTART = 3'd5;

  // Configuration register indexes
  localparam logic REG_PERIOD = 1'b0;
  localparam logic REG_ENABLE = 1'b1;

  localparam int unsigned TW        = 32;          // time and counter width
  localparam int unsigned IN_DATA_W = 40;          // now, hold, start_ok
  localparam int unsigned OUT_W     = 264;         // 258 bits of fields, byte padded
  localparam int unsigned DIV_STEPS = TW;          // one quotient bit per cycle
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [TW-1:0] PERIOD_RST = 32'd60000;

  // Divider result seen by the sequencer
  typedef struct packed {
    logic          done;
    logic [TW-1:0] quot;
    logic [TW-1:0] rem;
  } div_res_t;

  // Architectural scheduler state
  typedef struct packed {
    logic [TW-1:0] next_deadline;
    logic [TW-1:0] busy_start;
    logic [TW-1:0] busy_end;
    logic          busy_known;
    logic          pause_flag;
    logic [TW-1:0] requested_total;
    logic [TW-1:0] missed_total;
    logic [TW-1:0] skipped_total;
    logic [TW-1:0] epochs_total;
    logic [TW-1:0] epoch_start;
    logic [TW-1:0] starts_total;
    logic [TW-1:0] last_start;
    logic [TW-1:0] start_spacing;
  } sched_t;

endpackage

// ===== src/pwds_div.sv =====
// Restoring radix-2 divider: one quotient bit per cycle, 32 steps.
module pwds_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [pwds_pkg::TW-1:0] dividend,
  input  logic [pwds_pkg::TW-1:0] divisor,
  output pwds_pkg::div_res_t      res
);
  import pwds_pkg::*;

  logic [TW-1:0]        rem_r, rem_nxt;
  logic [TW-1:0]        quo_r, quo_nxt;
  logic [TW-1:0]        dvsr_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [TW:0]          trial;
  logic                 ge;

  // One shift-compare-subtract step
  always_comb begin
    trial   = {rem_r, quo_r[TW-1]};
    ge      = trial >= {1'b0, dvsr_r};
    rem_nxt = ge ? TW'(trial - {1'b0, dvsr_r}) : trial[TW-1:0];
    quo_nxt = {quo_r[TW-2:0], ge};
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= '0;
      quo_r  <= dividend;
      dvsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign res.done = done_r;
  assign res.quot = quo_r;
  assign res.rem  = rem_r;

endmodule

// ===== src/periodic_window_deadline_scheduler.sv =====
// Top level of the periodic window deadline scheduler: sequencer, state and stream ports.
//
// One event item is taken at a time. Window start, window end, pause, restart, unknown
// kinds, and ticks or resumes that find no deadline due go from acceptance through the
// execute step and the output step to a result in the output register. A tick or resume
// that finds a deadline due runs the elapsed time through the shared 32-step restoring
// divider between the execute step and the output step. The next item is accepted as
// soon as the sequencer is back to idle, even if the previous result has not yet been
// taken; while the output register still holds an untaken result, a finished item waits
// in the last sequencer step and the input stays not ready. A period of 0 behaves as a
// period of 1.
module periodic_window_deadline_scheduler (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration
  input  logic                           cfg_wr_en,
  input  logic                           cfg_addr,
  input  logic [pwds_pkg::TW-1:0]        cfg_wdata,
  // event input
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [pwds_pkg::IN_DATA_W-1:0] in_tdata,   // now_ms[31:0], hold, start_ok
  input  logic [2:0]                     in_tuser,   // kind
  // result output
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // start_request, deadlines_due, windows_requested, windows_missed, cycles_skipped,
  // epoch_count, epoch_start_ms, start_interval_ms, next_deadline_ms, paused
  output logic [pwds_pkg::OUT_W-1:0]     out_tdata
);
  import pwds_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]    state_r, state_nxt;
  sched_t        st_r, st_nxt;
  logic          req_r, req_nxt;
  logic [TW-1:0] due_r, due_nxt;
  logic [TW-1:0] period_r;
  logic          enable_r;
  logic [2:0]    kind_r;
  logic [TW-1:0] now_r;
  logic          hold_r;
  logic          can_r;
  logic          out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_data_r, out_data_nxt;

  logic [TW-1:0] per_eff;
  logic [TW-1:0] elapsed;
  logic          reached;
  logic          busy_hit;
  logic          grant;
  logic          div_start;
  logic          out_load;
  logic [TW-1:0] due_calc;
  div_res_t      div_res;

  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Shared divider: elapsed time over the period
  pwds_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (elapsed),
    .divisor  (per_eff),
    .res      (div_res)
  );

  // Common terms
  always_comb begin
    per_eff  = (period_r == '0) ? TW'(1) : period_r;
    elapsed  = now_r - st_r.next_deadline;
    reached  = ~elapsed[TW-1];
    busy_hit = st_r.busy_known &&
               ((st_r.next_deadline - st_r.busy_start) <= (st_r.busy_end - st_r.busy_start));
    due_calc = div_res.quot + TW'(1);
    grant    = (due_calc == TW'(1)) && can_r && !busy_hit;
  end

  // Sequencer and state update
  always_comb begin
    state_nxt = state_r;
    st_nxt    = st_r;
    req_nxt   = req_r;
    due_nxt   = due_r;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        req_nxt   = 1'b0;
        due_nxt   = '0;
        state_nxt = S_OUT;
        unique case (kind_r)
          KIND_TICK: begin
            if (enable_r && !st_r.pause_flag && !hold_r && reached) begin
              div_start = 1'b1;
              state_nxt = S_DIV;
            end
          end
          KIND_START: begin
            if (st_r.starts_total != '0) st_nxt.start_spacing = now_r - st_r.last_start;
            st_nxt.last_start   = now_r;
            st_nxt.starts_total = st_r.starts_total + TW'(1);
            st_nxt.busy_start   = now_r;
            st_nxt.busy_known   = 1'b0;
          end
          KIND_END: begin
            st_nxt.busy_end   = now_r;
            st_nxt.busy_known = 1'b1;
          end
          KIND_PAUSE: begin
            st_nxt.pause_flag = 1'b1;
          end
          KIND_RESUME: begin
            if (enable_r && reached) begin
              div_start = 1'b1;
              state_nxt = S_DIV;
            end else begin
              st_nxt.next_deadline = now_r + per_eff;
              st_nxt.busy_known    = 1'b0;
              st_nxt.pause_flag    = 1'b0;
            end
          end
          KIND_RESTART: begin
            st_nxt.next_deadline = now_r;
          end
          default: begin
          end
        endcase
      end
      S_DIV: begin
        if (div_res.done) begin
          state_nxt = S_OUT;
          if (kind_r == KIND_TICK) begin
            due_nxt                = due_calc;
            st_nxt.requested_total = st_r.requested_total + due_calc;
            if (grant) begin
              st_nxt.epoch_start  = st_r.next_deadline;
              st_nxt.epochs_total = st_r.epochs_total + TW'(1);
              req_nxt             = 1'b1;
            end else begin
              st_nxt.missed_total = st_r.missed_total + due_calc;
            end
            // due * period equals elapsed - remainder + period
            st_nxt.next_deadline = now_r - div_res.rem + per_eff;
          end else begin
            st_nxt.skipped_total = st_r.skipped_total + due_calc;
            st_nxt.next_deadline = now_r + per_eff;
            st_nxt.busy_known    = 1'b0;
            st_nxt.pause_flag    = 1'b0;
          end
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output register
  always_comb begin
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {6'd0, st_r.pause_flag, st_r.next_deadline, st_r.start_spacing,
                       st_r.epoch_start, st_r.epochs_total, st_r.skipped_total,
                       st_r.missed_total, st_r.requested_total, due_r, req_r};
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control and scheduler state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      st_r        <= '0;
      req_r       <= 1'b0;
      due_r       <= '0;
      out_valid_r <= 1'b0;
      period_r    <= PERIOD_RST;
      enable_r    <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      st_r        <= st_nxt;
      req_r       <= req_nxt;
      due_r       <= due_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_addr)
          REG_PERIOD: period_r <= cfg_wdata;
          REG_ENABLE: enable_r <= cfg_wdata[0];
          default: begin
          end
        endcase
      end
    end
  end

  // Item capture and result payload
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (in_tvalid && in_tready) begin
      kind_r <= in_tuser;
      now_r  <= in_tdata[TW-1:0];
      hold_r <= in_tdata[TW];
      can_r  <= in_tdata[TW+1];
    end
  end

  // Checks
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> (state_r == S_DIV))
    else $error("divider finished outside the divide phase");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second item accepted while one is in work");

  a_grant_single: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && req_r) |-> (due_r == TW'(1)))
    else $error("start request with other than one due deadline");

  a_div_for_tick_resume: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> (kind_r == KIND_TICK || kind_r == KIND_RESUME))
    else $error("divider started for an event that needs none");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the periodic window deadline scheduler stream block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pwds_pkg::*;

  // Event kinds the block treats as no-ops
  localparam logic [2:0] KIND_SPARE_A = 3'd6;
  localparam logic [2:0] KIND_SPARE_B = 3'd7;

  localparam int HOLD_OFF_CYCLES = 400;
  localparam int SETTLE_CYCLES   = 50;

  // One event item as driven on in_tuser / in_tdata
  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] now_ms;
    logic        hold;
    logic        start_ok;
  } evt_t;

  // One result item; field order matches out_tdata[257:0], top field highest
  typedef struct packed {
    logic        paused;
    logic [31:0] next_deadline_ms;
    logic [31:0] start_interval_ms;
    logic [31:0] epoch_start_ms;
    logic [31:0] epoch_count;
    logic [31:0] cycles_skipped;
    logic [31:0] windows_missed;
    logic [31:0] windows_requested;
    logic [31:0] deadlines_due;
    logic        start_request;
  } sched_report_t;

  logic              clk;
  logic              rst_n      = 1'b0;
  logic              cfg_wr_en  = 1'b0;
  logic              cfg_addr   = REG_PERIOD;
  logic [TW-1:0]     cfg_wdata  = '0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;  // now_ms[31:0], hold, start_ok
  logic [2:0]        in_tuser   = '0;   // kind
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  // start_request, deadlines_due, windows_requested, windows_missed, cycles_skipped,
  // epoch_count, epoch_start_ms, start_interval_ms, next_deadline_ms, paused
  logic [OUT_W-1:0]  out_tdata;

  periodic_window_deadline_scheduler dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Scheduler shadow: configuration and state
  logic [31:0] period_cfg = PERIOD_RST;
  logic        enable_cfg = 1'b1;
  logic [31:0] dl_next     = '0;
  logic [31:0] bz_start    = '0;
  logic [31:0] bz_end      = '0;
  logic        bz_valid    = 1'b0;
  logic        paused_st   = 1'b0;
  logic [31:0] req_total   = '0;
  logic [31:0] miss_total  = '0;
  logic [31:0] skip_total  = '0;
  logic [31:0] epoch_total = '0;
  logic [31:0] epoch_at    = '0;
  logic [31:0] start_total = '0;
  logic [31:0] prev_start  = '0;
  logic [31:0] start_gap   = '0;

  evt_t          event_backlog[$];
  sched_report_t due_reports[$];
  evt_t          cur_event    = '0;
  logic          event_loaded = 1'b0;

  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_off_left = 0;
  bit          hold_off_req  = 1'b0;
  int          mismatch_count = 0;
  int          results_seen   = 0;
  logic [31:0] gen_ms   = '0;
  logic [31:0] gen_step = '0;
  sched_report_t got_rep, want_rep;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Apply one event to the shadow state and return the result it should produce
  function automatic sched_report_t advance_schedule(input evt_t e);
    sched_report_t r;
    logic [31:0] p, span, off_d, off_e;
    p = (period_cfg == 32'd0) ? 32'd1 : period_cfg;
    span = e.now_ms - dl_next;
    r = '0;
    case (e.kind)
      KIND_TICK: begin
        if (enable_cfg && !paused_st && !e.hold && !span[31]) begin
          r.deadlines_due = span / p + 32'd1;
          req_total += r.deadlines_due;
          off_d = dl_next - bz_start;
          off_e = bz_end - bz_start;
          if (r.deadlines_due == 32'd1 && e.start_ok && !(bz_valid && off_d <= off_e)) begin
            epoch_at = dl_next;
            epoch_total += 32'd1;
            r.start_request = 1'b1;
          end else begin
            miss_total += r.deadlines_due;
          end
          dl_next += r.deadlines_due * p;
        end
      end
      KIND_START: begin
        if (start_total != 32'd0) start_gap = e.now_ms - prev_start;
        prev_start = e.now_ms;
        start_total += 32'd1;
        bz_start = e.now_ms;
        bz_valid = 1'b0;
      end
      KIND_END: begin
        bz_end = e.now_ms;
        bz_valid = 1'b1;
      end
      KIND_PAUSE: begin
        paused_st = 1'b1;
      end
      KIND_RESUME: begin
        // deadlines already passed at the resume are counted as skipped
        if (enable_cfg && !span[31]) skip_total += span / p + 32'd1;
        dl_next = e.now_ms + p;
        bz_valid = 1'b0;
        paused_st = 1'b0;
      end
      KIND_RESTART: begin
        dl_next = e.now_ms;
      end
      default: ;
    endcase
    r.windows_requested = req_total;
    r.windows_missed    = miss_total;
    r.cycles_skipped    = skip_total;
    r.epoch_count       = epoch_total;
    r.epoch_start_ms    = epoch_at;
    r.start_interval_ms = start_gap;
    r.next_deadline_ms  = dl_next;
    r.paused            = paused_st;
    return r;
  endfunction

  function automatic void push_event(input logic [2:0] kind, input logic [31:0] now_ms,
                                     input logic hold, input logic start_ok);
    evt_t e;
    e.kind = kind;
    e.now_ms = now_ms;
    e.hold = hold;
    e.start_ok = start_ok;
    event_backlog.push_back(e);
  endfunction

  // Mostly a coherent time line with random steps of at most gen_step; a few items are pure noise
  function automatic void push_random_event();
    int unsigned r;
    logic [2:0] kind;
    logic [31:0] now_ms;
    r = $urandom_range(99);
    gen_ms += $urandom_range(0, gen_step);
    now_ms = gen_ms;
    if (r < 50)      kind = KIND_TICK;
    else if (r < 60) kind = KIND_START;
    else if (r < 70) kind = KIND_END;
    else if (r < 74) kind = KIND_PAUSE;
    else if (r < 80) kind = KIND_RESUME;
    else if (r < 84) kind = KIND_RESTART;
    else if (r < 87) kind = ($urandom_range(1) != 0) ? KIND_SPARE_A : KIND_SPARE_B;
    else begin
      kind = 3'($urandom_range(7));
      now_ms = $urandom;
    end
    push_event(kind, now_ms, $urandom_range(9) == 0, $urandom_range(9) != 0);
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("result %0d: %s is %h, expected %h", results_seen, field, got, want);
    mismatch_count++;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (event_backlog.size() != 0 || event_loaded || due_reports.size() != 0);
  endtask

  task automatic write_config(input logic [31:0] period, input logic enable);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= REG_PERIOD;
    cfg_wdata <= period;
    @(posedge clk);
    cfg_addr  <= REG_ENABLE;
    cfg_wdata <= {31'b0, enable};
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    period_cfg = period;
    enable_cfg = enable;
    @(negedge clk);
  endtask

  // Reprogram while idle, then run a stretch of random events from a restart at base
  task automatic run_phase(input logic [31:0] period, input logic enable, input int count,
                           input logic [31:0] step_max, input logic [31:0] base,
                           input bit with_hold_off);
    wait_drained();
    write_config(period, enable);
    gen_ms = base;
    gen_step = step_max;
    push_event(KIND_RESTART, base, 1'b0, 1'b1);
    for (int i = 0; i < count; i++) push_random_event();
    if (with_hold_off) begin
      @(negedge clk);
      hold_off_req = 1'b1;
    end
    wait_drained();
  endtask

  // Input driver: holds each item until taken, random gaps between items
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        due_reports.push_back(advance_schedule(cur_event));
        event_loaded = 1'b0;
      end
      if (!event_loaded && event_backlog.size() != 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        cur_event = event_backlog.pop_front();
        event_loaded = 1'b1;
      end
      in_tvalid <= event_loaded;
      in_tdata  <= {6'b0, cur_event.start_ok, cur_event.hold, cur_event.now_ms};
      in_tuser  <= cur_event.kind;
    end
  end

  // Long receiver hold-off, counted here
  always @(posedge clk) begin
    if (hold_off_req) begin
      hold_off_left <= HOLD_OFF_CYCLES;
      hold_off_req = 1'b0;
    end else if (hold_off_left > 0) begin
      hold_off_left <= hold_off_left - 1;
    end
  end

  // Result monitor and checker
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        got_rep = out_tdata[$bits(sched_report_t)-1:0];
        if (due_reports.size() == 0) begin
          report_mismatch("item with no expectation", 32'd0, 32'd0);
        end else begin
          want_rep = due_reports.pop_front();
          if (got_rep.start_request !== want_rep.start_request)
            report_mismatch("start_request", 32'(got_rep.start_request),
                            32'(want_rep.start_request));
          if (got_rep.deadlines_due !== want_rep.deadlines_due)
            report_mismatch("deadlines_due", got_rep.deadlines_due, want_rep.deadlines_due);
          if (got_rep.windows_requested !== want_rep.windows_requested)
            report_mismatch("windows_requested", got_rep.windows_requested,
                            want_rep.windows_requested);
          if (got_rep.windows_missed !== want_rep.windows_missed)
            report_mismatch("windows_missed", got_rep.windows_missed, want_rep.windows_missed);
          if (got_rep.cycles_skipped !== want_rep.cycles_skipped)
            report_mismatch("cycles_skipped", got_rep.cycles_skipped, want_rep.cycles_skipped);
          if (got_rep.epoch_count !== want_rep.epoch_count)
            report_mismatch("epoch_count", got_rep.epoch_count, want_rep.epoch_count);
          if (got_rep.epoch_start_ms !== want_rep.epoch_start_ms)
            report_mismatch("epoch_start_ms", got_rep.epoch_start_ms, want_rep.epoch_start_ms);
          if (got_rep.start_interval_ms !== want_rep.start_interval_ms)
            report_mismatch("start_interval_ms", got_rep.start_interval_ms,
                            want_rep.start_interval_ms);
          if (got_rep.next_deadline_ms !== want_rep.next_deadline_ms)
            report_mismatch("next_deadline_ms", got_rep.next_deadline_ms,
                            want_rep.next_deadline_ms);
          if (got_rep.paused !== want_rep.paused)
            report_mismatch("paused", 32'(got_rep.paused), 32'(want_rep.paused));
        end
      end
      out_tready <= (hold_off_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Stimulus sequence
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 25;
    recv_idle_pct = 82;

    // directed events at reset configuration (period 60000, enabled)
    push_event(KIND_TICK,    32'd0,       1'b0, 1'b1);  // first deadline granted
    push_event(KIND_TICK,    32'd59999,   1'b0, 1'b1);  // not yet reached
    push_event(KIND_TICK,    32'd60000,   1'b1, 1'b1);  // held off
    push_event(KIND_TICK,    32'd60000,   1'b0, 1'b0);  // cannot start: missed
    push_event(KIND_START,   32'd100000,  1'b0, 1'b1);  // first start, no spacing yet
    push_event(KIND_END,     32'd130000,  1'b0, 1'b1);
    push_event(KIND_TICK,    32'd125000,  1'b0, 1'b1);  // deadline inside busy window
    push_event(KIND_TICK,    32'd400000,  1'b0, 1'b1);  // several due at once
    push_event(KIND_START,   32'd410000,  1'b0, 1'b1);  // spacing measured
    push_event(KIND_PAUSE,   32'd415000,  1'b0, 1'b1);
    push_event(KIND_TICK,    32'd430000,  1'b0, 1'b1);  // paused: ignored
    push_event(KIND_PAUSE,   32'd431000,  1'b0, 1'b1);  // pause while paused
    push_event(KIND_RESUME,  32'd600000,  1'b0, 1'b1);  // skipped deadlines counted
    push_event(KIND_RESUME,  32'd600100,  1'b0, 1'b1);  // resume when not paused
    push_event(KIND_RESTART, 32'hFFFFFFFF, 1'b0, 1'b1);
    push_event(KIND_TICK,    32'd5,       1'b0, 1'b1);  // reached across the wrap
    push_event(KIND_SPARE_A, 32'hAAAAAAAA, 1'b1, 1'b1);
    push_event(KIND_SPARE_B, 32'h55555555, 1'b0, 1'b0);
    push_event(KIND_RESTART, 32'd0,       1'b0, 1'b1);
    push_event(KIND_TICK,    32'h7FFFFFFF, 1'b0, 1'b1); // largest reachable lag
    push_event(KIND_RESTART, 32'd0,       1'b0, 1'b1);
    push_event(KIND_TICK,    32'h80000000, 1'b0, 1'b1); // lag reads as negative
    push_event(KIND_START,   32'hFFFFFF00, 1'b0, 1'b1);
    push_event(KIND_END,     32'h00000100, 1'b0, 1'b1); // busy window wraps zero
    push_event(KIND_RESTART, 32'd0,       1'b0, 1'b1);
    push_event(KIND_TICK,    32'd0,       1'b0, 1'b1);  // inside wrapped busy window

    // random stretches; first one also holds the receiver off for a long time
    run_phase(32'd1000, 1'b1, 500, 32'd2500, $urandom, 1'b1);
    run_phase(32'd0, 1'b1, 150, 32'd3, 32'hFFFFFF80, 1'b0);

    send_idle_pct = 82;
    recv_idle_pct = 25;
    run_phase(32'hFFFFFFFF, 1'b0, 150, 32'h40000000, $urandom, 1'b0);
    run_phase(32'hFFFFFFFF, 1'b1, 150, 32'h40000000, $urandom, 1'b0);
    run_phase(32'd60000, 1'b1, 300, 32'd150000, 32'hFFF00000, 1'b0);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase($urandom_range(2, 500), 1'b1, 300, 32'd1000, $urandom, 1'b0);
    run_phase(32'd1, 1'b1, 200, 32'd2, $urandom, 1'b0);

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && due_reports.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
